// ===== design/cgrf_pkg.sv =====
// ----------------------------------------------------------------------------
// cgrf_pkg
// Shared types and constants of the coset resample and fill core.
// ----------------------------------------------------------------------------
package cgrf_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned LENGTH_BITS = 20;
  localparam int unsigned OUT_BITS    = 22;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 6;
  localparam int unsigned STRIDE_W    = 6;
  localparam int unsigned OFFSET_W    = 6;
  localparam int unsigned SUB_W       = 4;
  localparam int unsigned POS_W       = 7;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRIDE_P        = 3'd0,
    CFG_STRIDE_Q        = 3'd1,
    CFG_GOING_UP        = 3'd2,
    CFG_START_OFFSET    = 3'd3,
    CFG_LENGTH_SUBTRACT = 3'd4,
    CFG_LEAD_ZERO       = 3'd5
  } cfg_idx_e;

  // Input item.
  typedef struct packed {
    logic [LENGTH_BITS-1:0] length_in;
    logic                   end_of_coset;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic signed [OUT_BITS-1:0] length_out;
    logic                       last_of_run;
  } out_item_t;

  // Configuration register set seen by the front end.
  typedef struct packed {
    logic [STRIDE_W-1:0] stride_p;
    logic [STRIDE_W-1:0] stride_q;
    logic                going_up;
    logic [OFFSET_W-1:0] start_offset;
    logic [SUB_W-1:0]    length_subtract;
    logic                lead_zero;
  } cfg_t;

  // Anchor command passed from the front end to the back end.
  typedef struct packed {
    logic signed [OUT_BITS-1:0] anchor;
    logic signed [OUT_BITS-1:0] prev;
    logic                       lead;
    logic                       fill;
    logic [STRIDE_W-1:0]        gap;
  } cmd_t;

endpackage

// ===== design/cgrf_front.sv =====
// ----------------------------------------------------------------------------
// cgrf_front
// Accepts input items, tracks position and stride phase, and turns every
// anchor into a command for the back end.
// ----------------------------------------------------------------------------
module cgrf_front import cgrf_pkg::*; #(
  parameter int unsigned MAX_STRIDE = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     push_i,
  input  in_item_t item_i,
  input  logic     full_i,
  output logic     cmd_push_o,
  output cmd_t     cmd_o
);

  localparam int unsigned SW = $clog2(MAX_STRIDE + 1);
  localparam int unsigned PW = $clog2(MAX_STRIDE);

  logic [POS_W-1:0]           pos_q, pos_d;
  logic [PW-1:0]              phase_q, phase_d;
  logic                       have_q, have_d;
  logic signed [OUT_BITS-1:0] prev_q, prev_d;

  logic [SW-1:0]              in_stride, gap;
  logic [SW-1:0]              ph_ext;
  logic [SW:0]                ph_inc;
  logic                       accept, is_anchor;
  logic signed [OUT_BITS-1:0] anchor_val;

  // Out-of-range strides act as the nearest legal value.
  function automatic logic [SW-1:0] clamp_stride(input logic [STRIDE_W-1:0] s);
    logic [SW-1:0] r;
    if (s == '0) begin
      r = SW'(1);
    end else if (32'(s) > MAX_STRIDE) begin
      r = SW'(MAX_STRIDE);
    end else begin
      r = SW'(s);
    end
    return r;
  endfunction

  // Position, phase and anchor decision for the item on the port.
  always_comb begin
    in_stride  = clamp_stride(cfg_i.going_up ? cfg_i.stride_q : cfg_i.stride_p);
    gap        = clamp_stride(cfg_i.going_up ? cfg_i.stride_p : cfg_i.stride_q);
    accept     = push_i && !full_i;
    anchor_val = OUT_BITS'(item_i.length_in) - OUT_BITS'(cfg_i.length_subtract);
    pos_d      = pos_q;
    phase_d    = phase_q;
    have_d     = have_q;
    prev_d     = prev_q;
    is_anchor  = 1'b0;
    ph_ext     = SW'(phase_q);
    ph_inc     = '0;
    if (pos_q < POS_W'(cfg_i.start_offset)) begin
      pos_d = pos_q + POS_W'(1);
    end else begin
      // A phase left beyond the stride by a register change restarts.
      if (ph_ext >= in_stride) begin
        ph_ext = '0;
      end
      is_anchor = (ph_ext == '0);
      ph_inc    = (SW + 1)'(ph_ext) + (SW + 1)'(1);
      phase_d   = (ph_inc >= (SW + 1)'(in_stride)) ? '0 : PW'(ph_inc);
      if (pos_q != {POS_W{1'b1}}) begin
        pos_d = pos_q + POS_W'(1);
      end
    end
    if (is_anchor) begin
      prev_d = anchor_val;
      have_d = 1'b1;
    end
    if (item_i.end_of_coset) begin
      pos_d   = '0;
      phase_d = '0;
      have_d  = 1'b0;
      prev_d  = '0;
    end
  end

  // Command for the back end.
  always_comb begin
    cmd_push_o   = accept && is_anchor;
    cmd_o.anchor = anchor_val;
    cmd_o.prev   = have_q ? prev_q : '0;
    cmd_o.lead   = !have_q && cfg_i.lead_zero;
    cmd_o.fill   = have_q || cfg_i.lead_zero;
    cmd_o.gap    = STRIDE_W'(gap);
  end

  // Per-coset state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= '0;
      have_q  <= 1'b0;
      prev_q  <= '0;
    end else if (accept) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
      have_q  <= have_d;
      prev_q  <= prev_d;
    end
  end

endmodule

// ===== design/cgrf_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// cgrf_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module cgrf_cmd_fifo import cgrf_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  // Pointer and fill count update.
  always_comb begin
    do_push = push_i && !full_o;
    do_pop  = pop_i && valid_o;
    wr_d    = wr_q;
    rd_d    = rd_q;
    cnt_d   = cnt_q;
    if (do_push) begin
      wr_d = (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  assign full_o  = (32'(cnt_q) == DEPTH);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== design/cgrf_back.sv =====
// ----------------------------------------------------------------------------
// cgrf_back
// Expands one anchor command into its lead zero, fill run and anchor, into
// the output register at one result per cycle while it is free or popped.
// ----------------------------------------------------------------------------
module cgrf_back import cgrf_pkg::*; #(
  parameter int unsigned MAX_STRIDE = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  cmd_t      cmd_i,
  output logic      cmd_pop_o,
  input  logic      pop_i,
  output logic      empty_o,
  output out_item_t item_o
);

  localparam int unsigned SW = $clog2(MAX_STRIDE + 1);

  logic [SW-1:0]              j_q, j_d;
  logic                       lead_done_q, lead_done_d;
  logic                       out_valid_q;
  out_item_t                  out_q, res;
  logic                       load;
  logic [SW-1:0]              gap_s;
  logic signed [OUT_BITS+1:0] left, right;

  // Candidate fill value for position j of the current segment.
  always_comb begin
    gap_s = cmd_i.gap[SW-1:0];
    left  = (OUT_BITS + 2)'(cmd_i.prev) + (OUT_BITS + 2)'(j_q);
    right = (OUT_BITS + 2)'(cmd_i.anchor) + (OUT_BITS + 2)'(gap_s)
            - (OUT_BITS + 2)'(j_q);
  end

  // Select the next result and advance the segment.
  always_comb begin
    load        = cmd_valid_i && (!out_valid_q || pop_i);
    res         = '0;
    cmd_pop_o   = 1'b0;
    j_d         = j_q;
    lead_done_d = lead_done_q;
    if (load) begin
      priority if (cmd_i.lead && !lead_done_q) begin
        lead_done_d = 1'b1;
      end else if (cmd_i.fill && (j_q < gap_s)) begin
        res.length_out = (left < right) ? left[OUT_BITS-1:0] : right[OUT_BITS-1:0];
        j_d            = j_q + SW'(1);
      end else begin
        res.length_out  = cmd_i.anchor;
        res.last_of_run = 1'b1;
        cmd_pop_o       = 1'b1;
        j_d             = SW'(1);
        lead_done_d     = 1'b0;
      end
    end
  end

  assign empty_o = !out_valid_q;
  assign item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_q         <= SW'(1);
      lead_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      j_q         <= j_d;
      lead_done_q <= lead_done_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

endmodule

// ===== design/coset_geodesic_resample_fill_core.sv =====
// ----------------------------------------------------------------------------
// coset_geodesic_resample_fill_core
// Resamples a coset length stream onto the adjacent coset and fills the
// positions between anchors.
// ----------------------------------------------------------------------------
// An anchor passes the command queue and the output register before its
// results reach the ports. One result per cycle leaves while the output
// register is free or popped: for an anchor with fill, its fill values and
// the anchor, after a lead zero when due; for a first anchor without lead
// zero, the anchor only; none for other items. The front end takes one item
// per cycle while the command queue has room. Reset clears all position,
// phase and anchor state and loads the configuration reset values.
module coset_geodesic_resample_fill_core import cgrf_pkg::*; #(
  parameter int unsigned MAX_STRIDE = 32,
  parameter int unsigned CMD_DEPTH  = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o
);

  cfg_t cfg_q;
  cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_pop, cmd_valid;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stride_p        <= STRIDE_W'(2);
      cfg_q.stride_q        <= STRIDE_W'(4);
      cfg_q.going_up        <= 1'b1;
      cfg_q.start_offset    <= '0;
      cfg_q.length_subtract <= '0;
      cfg_q.lead_zero       <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_STRIDE_P:        cfg_q.stride_p        <= cfg_wdata_i[STRIDE_W-1:0];
        CFG_STRIDE_Q:        cfg_q.stride_q        <= cfg_wdata_i[STRIDE_W-1:0];
        CFG_GOING_UP:        cfg_q.going_up        <= cfg_wdata_i[0];
        CFG_START_OFFSET:    cfg_q.start_offset    <= cfg_wdata_i[OFFSET_W-1:0];
        CFG_LENGTH_SUBTRACT: cfg_q.length_subtract <= cfg_wdata_i[SUB_W-1:0];
        CFG_LEAD_ZERO:       cfg_q.lead_zero       <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  cgrf_front #(
    .MAX_STRIDE(MAX_STRIDE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .item_i     (in_item_i),
    .full_i     (full),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  cgrf_cmd_fifo #(
    .DEPTH(CMD_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_head)
  );

  cgrf_back #(
    .MAX_STRIDE(MAX_STRIDE)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .item_o      (out_item_o)
  );

endmodule

// ===== design/cgrf_checker.sv =====
// ----------------------------------------------------------------------------
// cgrf_checker
// Port-level checks of the resample and fill core, bound to the top level.
// ----------------------------------------------------------------------------
module cgrf_checker import cgrf_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  push,
  input logic                  full,
  input logic                  empty,
  input logic                  pop,
  input out_item_t             out_item_o
);

  // A waiting result stays put until its transaction completes.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_item_o)))
    else $error("result changed or vanished while stalled");

  // The queue only fills up through an accepted input transaction.
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted input");

  // The queue only drains when the output register can take an anchor.
  a_full_fall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(full) |-> $past(empty || pop))
    else $error("queue drained while the output register was blocked");

endmodule

bind coset_geodesic_resample_fill_core cgrf_checker u_checker (.*);

// ===== dv/tb_coset_geodesic_resample_fill_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_coset_geodesic_resample_fill_core
// Self-checking bench for the coset resample and fill core. A directed table
// of items and register writes runs first, then random cosets under a series
// of register settings. Every accepted item is fed to a local resampler,
// which queues the lengths the core should produce unless the row is typed
// and gives its own; each popped result is checked against the oldest queued
// length. Both the push and the pop side idle at random.
// ----------------------------------------------------------------------------
module tb_coset_geodesic_resample_fill_core;
  import cgrf_pkg::*;

  localparam int unsigned MAX_STRIDE  = 32;
  localparam int unsigned POS_LIMIT   = 127;
  localparam int          IDLE_CYCLES = 8;
  localparam int          RAND_ITEMS  = 470;

  // One row of the directed table: a register write or an input item.
  typedef struct {
    bit              is_cfg;
    cfg_idx_e        idx;
    logic [5:0]      wdata;
    logic [19:0]     len;
    bit              eoc;
    bit              typed;
    int              n;
    longint          val;
  } dir_row_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  push        = 1'b0;
  logic                  full;
  in_item_t              in_item_i   = '0;
  logic                  empty;
  logic                  pop         = 1'b0;
  out_item_t             out_item_o;

  // Register mirror and resampler state.
  logic [5:0]  reg_p, reg_q, reg_off;
  logic        reg_up, reg_lz;
  logic [3:0]  reg_sub;
  logic [6:0]  st_pos;
  int unsigned st_phase;
  bit          st_have;
  longint      st_prev;

  out_item_t   resampled_q[$];
  dir_row_t    dir_rows[$];
  int          mismatch_cnt  = 0;
  int          pop_stall     = 0;
  bit          calm          = 1'b0;

  coset_geodesic_resample_fill_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  // Hard limit on the run time.
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned clamp_stride(input logic [5:0] s);
    if (s == 0) return 1;
    if (s > MAX_STRIDE) return MAX_STRIDE;
    return s;
  endfunction

  function automatic longint wrap22(input longint v);
    logic signed [OUT_BITS-1:0] t;
    t = v[OUT_BITS-1:0];
    return t;
  endfunction

  function automatic void queue_length(input longint v, input bit last, input bit keep);
    out_item_t r;
    r.length_out  = v[OUT_BITS-1:0];
    r.last_of_run = last;
    if (keep) resampled_q.push_back(r);
  endfunction

  // Resampler: advances position and phase, and queues the lead zero, fill run
  // and anchor whenever the item lands on an anchor position.
  function automatic void resample_item(input in_item_t it, input bit keep);
    int unsigned in_stride, gap;
    bit          anchor, fill;
    longint      a, prev, left, right;
    in_stride = clamp_stride(reg_up ? reg_q : reg_p);
    gap       = clamp_stride(reg_up ? reg_p : reg_q);
    anchor    = 1'b0;
    if (st_pos < {1'b0, reg_off}) begin
      st_pos++;
    end else begin
      if (st_phase >= in_stride) st_phase = 0;
      anchor   = (st_phase == 0);
      st_phase = (st_phase + 1 >= in_stride) ? 0 : st_phase + 1;
      if (st_pos < POS_LIMIT) st_pos++;
    end
    if (anchor) begin
      a    = wrap22(longint'(it.length_in) - longint'(reg_sub));
      prev = st_prev;
      fill = st_have;
      if (!st_have && reg_lz) begin
        queue_length(0, 1'b0, keep);
        prev = 0;
        fill = 1'b1;
      end
      if (fill) begin
        for (int unsigned j = 1; j < gap; j++) begin
          left  = prev + j;
          right = a + gap - j;
          queue_length(wrap22(left < right ? left : right), 1'b0, keep);
        end
      end
      queue_length(a, 1'b1, keep);
      st_prev = a;
      st_have = 1'b1;
    end
    if (it.end_of_coset) begin
      st_pos   = '0;
      st_phase = 0;
      st_have  = 1'b0;
      st_prev  = 0;
    end
  endfunction

  // Hold the sender until every queued length has come out, then let the
  // core settle for items that produce nothing.
  task automatic wait_idle();
    push <= 1'b0;
    while (resampled_q.size() != 0) @(posedge clk_i);
    repeat (IDLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_idx_e idx, input logic [5:0] data);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_STRIDE_P:        reg_p   = data;
      CFG_STRIDE_Q:        reg_q   = data;
      CFG_GOING_UP:        reg_up  = data[0];
      CFG_START_OFFSET:    reg_off = data;
      CFG_LENGTH_SUBTRACT: reg_sub = data[3:0];
      CFG_LEAD_ZERO:       reg_lz  = data[0];
      default: ;
    endcase
  endtask

  // Push one item and queue its lengths once the transaction is accepted.
  // A typed row queues the given lengths; the resampler only advances.
  task automatic send_item(input in_item_t it, input bit typed, input int n,
                           input longint val);
    int g;
    g = pick_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (full);
    if (typed) begin
      resample_item(it, 1'b0);
      if (n == 1) queue_length(val, 1'b1, 1'b1);
    end else begin
      resample_item(it, 1'b1);
    end
  endtask

  function automatic dir_row_t cfg_row(input cfg_idx_e idx, input logic [5:0] data);
    dir_row_t r;
    r.is_cfg = 1'b1; r.idx = idx; r.wdata = data;
    r.len = '0; r.eoc = 1'b0; r.typed = 1'b0; r.n = 0; r.val = 0;
    return r;
  endfunction

  function automatic dir_row_t item_row(input logic [19:0] len, input bit eoc,
                                        input bit typed, input int n, input longint val);
    dir_row_t r;
    r.is_cfg = 1'b0; r.idx = CFG_STRIDE_P; r.wdata = '0;
    r.len = len; r.eoc = eoc; r.typed = typed; r.n = n; r.val = val;
    return r;
  endfunction

  function automatic logic [19:0] pick_len();
    logic [31:0] r32;
    int          r;
    r   = $urandom_range(0, 9);
    r32 = $urandom();
    if (r == 0) return 20'($urandom_range(0, 15));
    if (r == 1) return 20'hFFFFF;
    if (r == 2) return 20'h0;
    return r32[19:0];
  endfunction

  // Result side: random pop stalls and the check against the queue.
  always @(posedge clk_i) begin
    out_item_t want;
    int        g;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (resampled_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result length %0d",
                                  out_item_o.length_out));
        end else begin
          want = resampled_q.pop_front();
          if (out_item_o.length_out !== want.length_out)
            flag_mismatch($sformatf("length_out %0d, want %0d",
                                    out_item_o.length_out, want.length_out));
          if (out_item_o.last_of_run !== want.last_of_run)
            flag_mismatch($sformatf("last_of_run %0b, want %0b",
                                    out_item_o.last_of_run, want.last_of_run));
        end
      end
      if (pop_stall > 0) begin
        pop <= 1'b0;
        pop_stall--;
      end else begin
        g = pick_gap();
        if (g > 0) begin
          pop       <= 1'b0;
          pop_stall = g - 1;
        end else begin
          pop <= 1'b1;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    in_item_t    it;
    int          sent, phase, in_phase, clen;
    bit          broken;
    logic [5:0]  np, nq, noff;
    logic        nup, nlz;
    logic [3:0]  nsub;

    reg_p = 6'd2; reg_q = 6'd4; reg_up = 1'b1;
    reg_off = '0; reg_sub = '0; reg_lz = 1'b0;
    st_pos = '0; st_phase = 0; st_have = 1'b0; st_prev = 0;

    // Directed table, starting from the reset settings (in-stride 4, gap 2).
    dir_rows.push_back(item_row(20'hFFFFF, 0, 1, 1, 1048575)); // first anchor alone
    dir_rows.push_back(item_row(20'h00000, 0, 1, 0, 0));       // non-anchors
    dir_rows.push_back(item_row(20'h12345, 0, 1, 0, 0));
    dir_rows.push_back(item_row(20'h00000, 0, 1, 0, 0));
    dir_rows.push_back(item_row(20'h00000, 0, 0, 0, 0));       // anchor with fill
    dir_rows.push_back(item_row(20'h00007, 1, 1, 0, 0));       // end of coset
    dir_rows.push_back(cfg_row(CFG_LENGTH_SUBTRACT, 6'd15));
    dir_rows.push_back(item_row(20'h00003, 0, 1, 1, -12));     // negative anchor
    dir_rows.push_back(cfg_row(CFG_STRIDE_Q, 6'd1));
    dir_rows.push_back(item_row(20'd100, 0, 0, 0, 0));         // phase past stride
    dir_rows.push_back(cfg_row(CFG_STRIDE_P, 6'd0));
    dir_rows.push_back(item_row(20'd50, 0, 1, 1, 35));         // gap of one
    dir_rows.push_back(item_row(20'd0, 1, 1, 1, -15));         // lowest length
    dir_rows.push_back(cfg_row(CFG_LEAD_ZERO, 6'd1));
    dir_rows.push_back(cfg_row(CFG_STRIDE_P, 6'd63));
    dir_rows.push_back(item_row(20'hFFFFF, 0, 0, 0, 0));       // lead zero, widest run
    dir_rows.push_back(cfg_row(CFG_GOING_UP, 6'd0));
    dir_rows.push_back(cfg_row(CFG_START_OFFSET, 6'd63));
    dir_rows.push_back(item_row(20'd1, 1, 1, 0, 0));           // before start offset
    dir_rows.push_back(cfg_row(CFG_START_OFFSET, 6'd0));
    dir_rows.push_back(cfg_row(CFG_LENGTH_SUBTRACT, 6'd0));
    dir_rows.push_back(item_row(20'hAAAAA, 0, 0, 0, 0));       // lead zero, gap one
    dir_rows.push_back(item_row(20'h55555, 1, 1, 0, 0));       // after last anchor

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        write_cfg(dir_rows[i].idx, dir_rows[i].wdata);
      end else begin
        it.length_in    = dir_rows[i].len;
        it.end_of_coset = dir_rows[i].eoc;
        send_item(it, dir_rows[i].typed, dir_rows[i].n, dir_rows[i].val);
      end
    end

    // Random cosets, one register setting per phase.
    sent  = 0;
    phase = 0;
    while (sent < RAND_ITEMS) begin
      case (phase % 5)
        0: begin np = 0;  nq = 0;  nup = 0; noff = 0;  nsub = 0;  nlz = 0; end
        1: begin np = 63; nq = 63; nup = 1; noff = 63; nsub = 15; nlz = 1; end
        2: begin np = 63; nq = 1;  nup = 1; noff = 0;  nsub = 15; nlz = 1; end
        default: begin
          np   = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 9));
          nq   = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 9));
          nup  = 1'($urandom_range(0, 1));
          noff = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 6));
          nsub = 4'($urandom_range(0, 15));
          nlz  = 1'($urandom_range(0, 1));
        end
      endcase
      calm = 1'b0;
      write_cfg(CFG_STRIDE_P, np);
      write_cfg(CFG_STRIDE_Q, nq);
      write_cfg(CFG_GOING_UP, {5'd0, nup});
      write_cfg(CFG_START_OFFSET, noff);
      write_cfg(CFG_LENGTH_SUBTRACT, {2'd0, nsub});
      write_cfg(CFG_LEAD_ZERO, {5'd0, nlz});
      calm = ($urandom_range(0, 3) == 0);

      in_phase = 0;
      while (in_phase < 47) begin
        // Mostly whole cosets; now and then one runs on without its end mark.
        clen   = (reg_off > 8) ? $urandom_range(reg_off + 1, reg_off + 70)
                               : $urandom_range(1, 24);
        broken = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < clen; i++) begin
          it.length_in    = pick_len();
          it.end_of_coset = (i == clen - 1) && !broken;
          send_item(it, 1'b0, 0, 0);
          in_phase++;
          sent++;
        end
        if ($urandom_range(0, 39) == 0) wait_idle();
      end
      phase++;
    end

    // Drain and settle.
    push <= 1'b0;
    while (resampled_q.size() != 0) @(posedge clk_i);
    repeat (5 * IDLE_CYCLES) @(posedge clk_i);
    if (resampled_q.size() != 0)
      flag_mismatch($sformatf("%0d lengths never produced", resampled_q.size()));
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/cgrf_pkg.sv
design/cgrf_front.sv
design/cgrf_cmd_fifo.sv
design/cgrf_back.sv
design/coset_geodesic_resample_fill_core.sv
design/cgrf_checker.sv
dv/tb_coset_geodesic_resample_fill_core.sv
